[hdl/sbi_pkg.sv]
// Shared types and constants for the segment/box intersection unit.
// No dependencies; imported by sbi_div, segment_box_intersect_unit and the bench.
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

    localparam int COORD_W     = 32;
    localparam int HALF_W      = 31;
    localparam int EPS_W       = 16;
    localparam int P_W         = COORD_W + 1;
    localparam int NUM_W       = COORD_W + 3;
    localparam int MAG_W       = COORD_W;
    localparam int TP_W        = COORD_W + MAG_W + 1;
    localparam int PROD_W      = NUM_W + MAG_W + 1;
    localparam int LAMBDA_BITS = 16;
    localparam int CLOSE_W     = LAMBDA_BITS + 1;
    localparam int DIV_STEPS   = LAMBDA_BITS + 1;
    localparam logic [CLOSE_W-1:0] LAMBDA_ONE = CLOSE_W'(1) << LAMBDA_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 192;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPSILON  = 3'd6,
        REG_MODE     = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic valid;
        logic in_box;
        logic tinside;
    } t_flags;

endpackage

`default_nettype wire

[hdl/segment_box_intersect_unit.sv]
// Top level of the segment/box intersection unit.
// Depends on sbi_pkg and sbi_div.
//
// Usage: write the segment origin, direction, axis epsilon and mode through
// the configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) while no beat is
// in flight. Each slave beat carries one box (center and half extents); each
// master beat carries one result (hit flag and closest lambda in Q1.16).
// Throughput: one box per cycle while the receiver is not stalling. Pipeline:
// six stages of setup, face range checks, the cross-multiplied bound checks
// and face selection, then 17 stages of the per-axis lambda divider (one
// quotient bit each), then the output register.
// Reset clears the configuration and all valid bits; the pipeline is empty
// afterward. When the receiver stalls, the whole pipeline holds in place and
// s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module segment_box_intersect_unit
    import sbi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit, closest, zero pad
    output logic      [M_TDATA_W-1:0]  m_axis_tdata
);

    logic signed [COORD_W-1:0] r_org [3];
    logic signed [COORD_W-1:0] r_dir [3];
    logic        [EPS_W-1:0]   r_eps;
    logic                      r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a] <= '0;
                r_dir[a] <= '0;
            end
            r_eps  <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                REG_EPSILON:  r_eps    <= i_cfg_data[EPS_W-1:0];
                REG_MODE:     r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic en;
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: offset of origin from box center
    logic                    r1_v;
    logic signed [P_W-1:0]   r1_p [3];
    logic        [HALF_W-1:0] r1_h [3];
    logic signed [P_W-1:0]   n1_p [3];
    logic        [HALF_W-1:0] n1_h [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_p[a] = P_W'(r_org[a]) -
                      P_W'($signed(s_axis_tdata[COORD_W*a +: COORD_W]));
            n1_h[a] = s_axis_tdata[3*COORD_W + HALF_W*a +: HALF_W];
        end
    end

    // stage 2: face offsets and inside tests
    t_flags                  r2_fl, n2_fl;
    logic signed [NUM_W-1:0] r2_hi [3], r2_lo [3];
    logic signed [NUM_W-1:0] n2_hi [3], n2_lo [3];

    always_comb begin
        logic signed [NUM_W-1:0] hs, ps, qs;
        n2_fl.valid   = r1_v;
        n2_fl.in_box  = 1'b1;
        n2_fl.tinside = 1'b1;
        for (int a = 0; a < 3; a++) begin
            hs = NUM_W'($signed({1'b0, r1_h[a]}));
            ps = NUM_W'(r1_p[a]);
            qs = ps + NUM_W'(r_dir[a]);
            n2_hi[a] = hs - ps;
            n2_lo[a] = -hs - ps;
            if (ps > hs || ps < -hs) n2_fl.in_box = 1'b0;
            if (qs > hs || qs < -hs) n2_fl.tinside = 1'b0;
        end
    end

    // stage 3: orient numerators by direction sign, check lambda in [0,1]
    t_flags                  r3_fl;
    logic        [MAG_W-1:0] r3_nn [3][2], n3_nn [3][2];
    logic                    r3_ok [3][2], n3_ok [3][2];
    logic        [MAG_W-1:0] r3_dd [3], n3_dd [3];
    logic signed [NUM_W-1:0] r3_hi [3], r3_lo [3];

    always_comb begin
        logic signed [P_W-1:0]   ds;
        logic        [P_W-1:0]   dm;
        logic signed [NUM_W-1:0] nn;
        logic                    dneg;
        for (int a = 0; a < 3; a++) begin
            dneg     = r_dir[a][COORD_W-1];
            ds       = P_W'(r_dir[a]);
            dm       = dneg ? -ds : ds;
            n3_dd[a] = dm[MAG_W-1:0];
            for (int s = 0; s < 2; s++) begin
                nn = (s == 0) ? r2_hi[a] : r2_lo[a];
                if (dneg) nn = -nn;
                n3_nn[a][s] = nn[MAG_W-1:0];
                n3_ok[a][s] = (dm[MAG_W-1:0] > MAG_W'(r_eps)) && !nn[NUM_W-1] &&
                              ($unsigned(nn) <= NUM_W'(dm[MAG_W-1:0]));
            end
        end
    end

    // stage 4: cross products for the in-face bounds
    t_flags                   r4_fl;
    logic signed [PROD_W-1:0] r4_t [3][2][2], n4_t [3][2][2];
    logic signed [PROD_W-1:0] r4_l [3][2], n4_l [3][2];
    logic signed [PROD_W-1:0] r4_u [3][2], n4_u [3][2];
    logic        [MAG_W-1:0]  r4_nn [3][2];
    logic                     r4_ok [3][2];
    logic        [MAG_W-1:0]  r4_dd [3];

    always_comb begin
        logic signed [TP_W-1:0]   tp;
        logic signed [PROD_W-1:0] lp, up;
        int b;
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 2; k++) begin
                b = a + k + 1;
                if (b >= 3) b = b - 3;
                lp = PROD_W'(r3_lo[b]) * PROD_W'($signed({1'b0, r3_dd[a]}));
                up = PROD_W'(r3_hi[b]) * PROD_W'($signed({1'b0, r3_dd[a]}));
                n4_l[a][k] = lp;
                n4_u[a][k] = up;
                for (int s = 0; s < 2; s++) begin
                    tp = TP_W'(r_dir[b]) * TP_W'($signed({1'b0, r3_nn[a][s]}));
                    n4_t[a][s][k] = PROD_W'(tp);
                end
            end
        end
    end

    // stage 5: bound compares
    t_flags             r5_fl;
    logic               r5_pass [3][2], n5_pass [3][2];
    logic [MAG_W-1:0]   r5_nn [3][2];
    logic [MAG_W-1:0]   r5_dd [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 2; s++) begin
                n5_pass[a][s] = r4_ok[a][s];
                for (int k = 0; k < 2; k++) begin
                    if (r4_t[a][s][k] < r4_l[a][k] || r4_t[a][s][k] > r4_u[a][k])
                        n5_pass[a][s] = 1'b0;
                end
            end
        end
    end

    // stage 6: nearer face of each axis
    t_flags           r6_fl;
    logic [MAG_W-1:0] r6_num [3], n6_num [3];
    logic [MAG_W-1:0] r6_den [3];
    logic             r6_ok [3], n6_ok [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n6_ok[a] = r5_pass[a][0] || r5_pass[a][1];
            if (r5_pass[a][0] && r5_pass[a][1])
                n6_num[a] = (r5_nn[a][0] <= r5_nn[a][1]) ? r5_nn[a][0] : r5_nn[a][1];
            else if (r5_pass[a][0])
                n6_num[a] = r5_nn[a][0];
            else
                n6_num[a] = r5_nn[a][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_fl <= '0;
            r3_fl <= '0;
            r4_fl <= '0;
            r5_fl <= '0;
            r6_fl <= '0;
        end else if (en) begin
            r1_v  <= s_axis_tvalid;
            r2_fl <= n2_fl;
            r3_fl <= r2_fl;
            r4_fl <= r3_fl;
            r5_fl <= r4_fl;
            r6_fl <= r5_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p  <= n1_p;
            r1_h  <= n1_h;
            r2_hi <= n2_hi;
            r2_lo <= n2_lo;
            r3_nn <= n3_nn;
            r3_ok <= n3_ok;
            r3_dd <= n3_dd;
            r3_hi <= r2_hi;
            r3_lo <= r2_lo;
            r4_t  <= n4_t;
            r4_l  <= n4_l;
            r4_u  <= n4_u;
            r4_nn <= r3_nn;
            r4_ok <= r3_ok;
            r4_dd <= r3_dd;
            r5_pass <= n5_pass;
            r5_nn   <= r4_nn;
            r5_dd   <= r4_dd;
            r6_num  <= n6_num;
            r6_den  <= r5_dd;
            r6_ok   <= n6_ok;
        end
    end

    // lambda dividers, one per axis
    logic [CLOSE_W-1:0] w_quo [3];
    logic               w_qok [3];

    for (genvar g = 0; g < 3; g++) begin : g_div
        sbi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r6_num[g]),
            .i_den (r6_den[g]),
            .i_ok  (r6_ok[g]),
            .o_quo (w_quo[g]),
            .o_ok  (w_qok[g])
        );
    end

    t_flags r_dfl [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STEPS; i++) r_dfl[i] <= '0;
        end else if (en) begin
            r_dfl[0] <= r6_fl;
            for (int i = 1; i < DIV_STEPS; i++) r_dfl[i] <= r_dfl[i-1];
        end
    end

    // output stage
    t_flags             w_fl;
    logic [CLOSE_W-1:0] w_best;
    logic               w_face, w_early;
    logic               n_hit;
    logic [CLOSE_W-1:0] n_close;
    logic               r_hit;
    logic [CLOSE_W-1:0] r_close;

    always_comb begin
        w_fl   = r_dfl[DIV_STEPS-1];
        w_best = LAMBDA_ONE;
        w_face = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (w_qok[a]) begin
                w_face = 1'b1;
                if (w_quo[a] < w_best) w_best = w_quo[a];
            end
        end
        w_early = w_fl.in_box || (!r_mode && w_fl.tinside);
        n_hit   = w_early || w_face;
        n_close = (w_early || !r_mode) ? '0 : w_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_fl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit   <= n_hit;
            r_close <= n_close;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - CLOSE_W - 1){1'b0}}, r_close, r_hit};

    a_miss_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_hit |-> (r_close == '0 || r_close == LAMBDA_ONE))
        else $error("miss with a partial lambda");

    a_close_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_close <= LAMBDA_ONE)
        else $error("lambda above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dfl[DIV_STEPS-1]) && $stable(r6_fl))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[hdl/sbi_div.sv]
// Pipelined restoring divider: floor(num * 2^16 / den) for num <= den.
// One quotient bit per stage; depends on sbi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbi_div
    import sbi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [MAG_W-1:0]   i_num,
    input  wire logic [MAG_W-1:0]   i_den,
    input  wire logic               i_ok,
    output logic      [CLOSE_W-1:0] o_quo,
    output logic                    o_ok
);

    logic [MAG_W-1:0]   r_rem [DIV_STEPS];
    logic [MAG_W-1:0]   r_den [DIV_STEPS];
    logic [CLOSE_W-1:0] r_quo [DIV_STEPS];
    logic               r_ok  [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_num >= i_den) begin
                r_rem[0] <= i_num - i_den;
                r_quo[0] <= CLOSE_W'(1);
            end else begin
                r_rem[0] <= i_num;
                r_quo[0] <= '0;
            end
            r_den[0] <= i_den;
            r_ok[0]  <= i_ok;
        end
    end

    for (genvar g = 1; g < DIV_STEPS; g++) begin : g_step
        logic [MAG_W:0] w_sh;
        logic [MAG_W:0] w_diff;
        assign w_sh   = {r_rem[g-1], 1'b0};
        assign w_diff = w_sh - {1'b0, r_den[g-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_diff[MAG_W] ? w_sh[MAG_W-1:0] : w_diff[MAG_W-1:0];
                r_quo[g] <= {r_quo[g-1][CLOSE_W-2:0], ~w_diff[MAG_W]};
                r_den[g] <= r_den[g-1];
                r_ok[g]  <= r_ok[g-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];
    assign o_ok  = r_ok[DIV_STEPS-1];

endmodule

`default_nettype wire

[bench/segment_box_intersect_unit_tb.sv]
// Self-checking bench for segment_box_intersect_unit: directed table, then random boxes.
// Random boxes and untabled rows are checked against an exact wide-integer hit/lambda predictor.
// Depends on sbi_pkg and the segment_box_intersect_unit RTL.
`timescale 1ns / 1ps

module segment_box_intersect_unit_tb;
    import sbi_pkg::*;

    typedef logic signed [95:0] t_wide;
    typedef t_wide t_vec3 [3];

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
        logic [15:0]        eps;
        logic               mode;
    } t_seg;

    typedef struct packed {
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        hx, hy, hz;
    } t_box;

    typedef struct packed {
        logic        hit;
        logic [16:0] closest;
    } t_hit;

    typedef struct {
        logic reconf;
        t_seg seg;
        t_box box;
        logic known;
        t_hit want;
    } t_row;

    localparam int LATENCY = 24;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // hit, closest, zero pad
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    segment_box_intersect_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    t_seg  seg_now;
    t_hit  pending_hits[$];
    t_row  rows[$];
    int    fail_count;
    int    idle_cycles;
    logic  calm;
    int    stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_wide wabs(t_wide v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_wide floor_q(t_wide t, t_wide den);
        t_wide q;
        q = t / den;
        if ((t % den) != 0 && t < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_wide ceil_q(t_wide t, t_wide den);
        t_wide q;
        q = t / den;
        if ((t % den) != 0 && t > 0) q = q + 1;
        return q;
    endfunction

    // lambda of crossing face (a, side) scaled by 2^16, or -1 when missed
    function automatic t_wide face_lambda(t_vec3 p, t_vec3 h, t_vec3 d, int a, int side);
        t_wide num, den, t;
        int b;
        num = (side > 0 ? h[a] : -h[a]) - p[a];
        den = d[a];
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (den == 0 || num < 0 || num > den) return -1;
        for (int k = 1; k <= 2; k++) begin
            b = (a + k) % 3;
            t = d[b] * num;
            if (floor_q(t, den) < -h[b] - p[b] || ceil_q(t, den) > h[b] - p[b]) return -1;
        end
        return (num <<< LAMBDA_BITS) / den;
    endfunction

    function automatic t_hit segment_box_hit(t_seg s, t_box bx);
        t_vec3 o, d, c, h, p;
        logic ins, tins, hit;
        t_wide best, l;
        t_hit r;
        o[0] = s.ox; o[1] = s.oy; o[2] = s.oz;
        d[0] = s.dx; d[1] = s.dy; d[2] = s.dz;
        c[0] = bx.cx; c[1] = bx.cy; c[2] = bx.cz;
        h[0] = {65'd0, bx.hx}; h[1] = {65'd0, bx.hy}; h[2] = {65'd0, bx.hz};
        ins = 1'b1;
        tins = 1'b1;
        hit = 1'b0;
        best = t_wide'(LAMBDA_ONE);
        for (int a = 0; a < 3; a++) begin
            p[a] = o[a] - c[a];
            if (wabs(p[a]) > h[a]) ins = 1'b0;
            if (wabs(p[a] + d[a]) > h[a]) tins = 1'b0;
        end
        if (ins || (!s.mode && tins)) begin
            r.hit = 1'b1;
            r.closest = '0;
            return r;
        end
        for (int a = 0; a < 3; a++) begin
            if (wabs(d[a]) > {80'd0, s.eps}) begin
                for (int sd = -1; sd <= 1; sd += 2) begin
                    l = face_lambda(p, h, d, a, sd);
                    if (l >= 0) begin
                        hit = 1'b1;
                        if (l < best) best = l;
                    end
                end
            end
        end
        r.hit = hit;
        r.closest = s.mode ? best[16:0] : 17'd0;
        return r;
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait out the pipeline, then load the whole segment
    task automatic load_segment(t_seg s);
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        write_reg(REG_ORIGIN_X, s.ox);
        write_reg(REG_ORIGIN_Y, s.oy);
        write_reg(REG_ORIGIN_Z, s.oz);
        write_reg(REG_DIR_X, s.dx);
        write_reg(REG_DIR_Y, s.dy);
        write_reg(REG_DIR_Z, s.dz);
        write_reg(REG_EPSILON, {16'd0, s.eps});
        write_reg(REG_MODE, {31'd0, s.mode});
        seg_now = s;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_box(t_box bx, logic known, t_hit want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_hits.push_back(known ? want : segment_box_hit(seg_now, bx));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'd0, bx.hz, bx.hy, bx.hx, bx.cz, bx.cy, bx.cx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] span(int sc);
        logic [31:0] v;
        v = $urandom;
        return v >> (31 - sc);
    endfunction

    function automatic t_seg random_segment(int kind, int sc);
        t_seg s;
        s.ox = $urandom; s.oy = $urandom; s.oz = $urandom;
        s.dx = $urandom; s.dy = $urandom; s.dz = $urandom;
        s.eps = 16'($urandom);
        s.mode = 1'($urandom);
        if (kind == 0) begin
            s.ox = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.oy = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.oz = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.dx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.dy = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.dz = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            s.eps = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (kind >= 2) begin
            s.ox = $signed(span(sc)) - $signed(span(sc));
            s.oy = $signed(span(sc)) - $signed(span(sc));
            s.oz = $signed(span(sc)) - $signed(span(sc));
            s.dx = $signed(span(sc)) - $signed(span(sc));
            s.dy = $signed(span(sc)) - $signed(span(sc));
            s.dz = $signed(span(sc)) - $signed(span(sc));
            if ($urandom_range(0, 3) == 0) s.dx = 32'sd0;
            if ($urandom_range(0, 3) == 0) s.dy = 32'sd0;
            s.eps = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'd0;
        end
        return s;
    endfunction

    function automatic logic signed [31:0] along(logic signed [31:0] o, logic signed [31:0] d,
                                                 int frac, int sc);
        t_wide v;
        v = o + ((t_wide'(d) * frac) >>> 16) + $signed(span(sc - 1)) - $signed(span(sc - 1));
        return v[31:0];
    endfunction

    function automatic t_box random_box(int sc);
        t_box bx;
        int frac;
        bx.cx = $urandom; bx.cy = $urandom; bx.cz = $urandom;
        bx.hx = 31'($urandom); bx.hy = 31'($urandom); bx.hz = 31'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            frac = $urandom_range(0, 80000) - 6000;
            bx.cx = along(seg_now.ox, seg_now.dx, frac, sc);
            bx.cy = along(seg_now.oy, seg_now.dy, frac, sc);
            bx.cz = along(seg_now.oz, seg_now.dz, frac, sc);
            bx.hx = 31'(span(sc));
            bx.hy = 31'(span(sc));
            bx.hz = 31'(span(sc));
        end
        return bx;
    endfunction

    function automatic void add_row(logic reconf, t_seg s, t_box bx, logic known,
                                    logic hit, logic [16:0] closest);
        t_row r;
        r.reconf = reconf;
        r.seg = s;
        r.box = bx;
        r.known = known;
        r.want.hit = hit;
        r.want.closest = closest;
        rows.push_back(r);
    endfunction

    // result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_hit got, exp_hit;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit = m_axis_tdata[0];
                got.closest = m_axis_tdata[17:1];
                if (pending_hits.size() == 0) begin
                    $error("beat with nothing expected: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_hit = pending_hits.pop_front();
                    if (got.hit !== exp_hit.hit) begin
                        $error("hit: expected %0d, got %0d", exp_hit.hit, got.hit);
                        fail_count++;
                    end
                    if (got.closest !== exp_hit.closest) begin
                        $error("closest: expected %0d, got %0d", exp_hit.closest,
                               got.closest);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall_left <= $urandom_range(0, 99) < 85 ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("segment_box_intersect_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_seg s;
        t_box bx;
        t_hit none;
        int sc;
        int kind;
        none = '0;
        calm = 1'b0;
        seg_now = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        s = '0;
        add_row(0, s, '{0, 0, 0, 0, 0, 0}, 1, 1, 0);
        add_row(0, s, '{1, 0, 0, 0, 0, 0}, 1, 0, 0);
        add_row(0, s, '{32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 0, 0}, 1, 0, 0);
        add_row(0, s, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 1, 1, 0);
        add_row(0, s, '{32'hFFFF_FFFF, 0, 5, 1, 0, 4}, 1, 0, 0);
        s.dx = 32'sd65536;
        s.mode = 1'b1;
        add_row(1, s, '{65536 + 1024, 0, 0, 1024, 1024, 1024}, 1, 1, 17'd65536);
        add_row(0, s, '{32768, 0, 0, 1024, 1024, 1024}, 1, 1, 17'd31744);
        add_row(0, s, '{-5000, 0, 0, 1024, 1024, 1024}, 1, 0, 17'd65536);
        add_row(0, s, '{0, 0, 0, 0, 0, 0}, 1, 1, 0);
        add_row(0, s, '{32768, 2000, 0, 1024, 1024, 1024}, 0, 0, 0);
        s.dx = 32'sd65535;
        s.eps = 16'hFFFF;
        add_row(1, s, '{32768, 0, 0, 1024, 1024, 1024}, 1, 0, 17'd65536);
        s.dx = 32'sd65536;
        s.mode = 1'b0;
        add_row(1, s, '{65536, 0, 0, 100, 100, 100}, 1, 1, 0);
        add_row(0, s, '{32768, 0, 0, 100, 100, 100}, 0, 0, 0);
        s = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 16'd0, 1'b1};
        add_row(1, s, '{0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 0, 0, 0);
        add_row(0, s, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        31'h4000_0000, 31'h4000_0000, 31'h4000_0000}, 0, 0, 0);
        add_row(0, s, '{32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0}, 0, 0, 0);
        add_row(0, s, '{32'h0, 32'h4000_0000, 32'h4000_0000, 31'h3FFF_FFFF, 0, 31'h1}, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].reconf) load_segment(rows[i].seg);
            send_box(rows[i].box, rows[i].known, rows[i].want);
        end

        for (int ph = 0; ph < 16; ph++) begin
            kind = ph < 2 ? ph : $urandom_range(1, 6);
            sc = $urandom_range(12, 28);
            load_segment(random_segment(kind, sc));
            calm = (ph % 5 == 3);
            if (kind < 2) sc = 30;
            for (int n = 0; n < 102; n++) begin
                bx = random_box(sc);
                send_box(bx, 1'b0, none);
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        if (fail_count == 0 && pending_hits.size() == 0) begin
            $display("segment_box_intersect_unit verification clean");
        end else begin
            $display("segment_box_intersect_unit verification failed");
        end
        $finish;
    end

endmodule

[segment_box_intersect_unit.f]
hdl/sbi_pkg.sv
hdl/sbi_div.sv
hdl/segment_box_intersect_unit.sv
bench/segment_box_intersect_unit_tb.sv
